FILE: rtl/lphm_pkg.sv
`default_nettype none
package lphm_pkg;

   // Table geometry; the slot count must be a power of two.
   localparam int SLOTS     = 1024;
   localparam int SLOT_BITS = $clog2(SLOTS);
   localparam logic [SLOT_BITS-1:0] SLOT_MAX = SLOT_BITS'(SLOTS - 1);

   localparam int KEY_W   = 64;
   localparam int VALUE_W = 32;
   localparam int KIND_W  = 2;
   localparam int LIMIT_W = 11;
   localparam int HALF_W  = KEY_W / 2;

   localparam logic [LIMIT_W-1:0] LIVE_LIMIT_RESET = LIMIT_W'(716);

   // fmix64 finalizer constants
   localparam logic [KEY_W-1:0] FMIX_C1    = 64'hff51afd7ed558ccd;
   localparam logic [KEY_W-1:0] FMIX_C2    = 64'hc4ceb9fe1a85ec53;
   localparam int               FMIX_SHIFT = 33;

   // Operation codes
   localparam logic [KIND_W-1:0] KIND_LOOKUP   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_EXCHANGE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR    = 2'd2;

   typedef enum logic [1:0] {
      MARK_EMPTY = 2'd0,
      MARK_FULL  = 2'd1,
      MARK_TOMB  = 2'd2
   } mark_type;

   typedef struct packed {
      mark_type                  mark;
      logic [KEY_W-1:0]          key;
      logic [VALUE_W-1:0]        value;
   } slot_entry_type;

   typedef enum logic [2:0] {
      C_SWEEP,
      C_IDLE,
      C_HASH,
      C_PROBE,
      C_FINISH
   } ctrl_state_type;

   typedef enum logic [1:0] {
      H_IDLE,
      H_LL,
      H_LH,
      H_HL
   } hash_state_type;

   typedef struct packed {
      logic              start;
      logic [KEY_W-1:0]  key;
   } hash_req_type;

   typedef struct packed {
      logic                  done;
      logic [SLOT_BITS-1:0]  slot;
   } hash_rsp_type;

   typedef struct packed {
      logic                  en;
      logic [SLOT_BITS-1:0]  addr;
   } tbl_rd_type;

   typedef struct packed {
      logic                  en;
      logic [SLOT_BITS-1:0]  addr;
      slot_entry_type        entry;
   } tbl_wr_type;

endpackage
`default_nettype wire

FILE: rtl/lphm_hash.sv
`default_nettype none
// fmix64 on one shared 32x32 multiplier: each 64-bit product (low half)
// takes three partial products, two multiplications per hash.
module lphm_hash (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire lphm_pkg::hash_req_type hash_req,
   output lphm_pkg::hash_rsp_type      hash_rsp
);

   lphm_pkg::hash_state_type state_ff, state_in;
   logic                            pass_ff, pass_in;
   logic [lphm_pkg::KEY_W-1:0]      h_ff, h_in;
   logic [lphm_pkg::KEY_W-1:0]      acc_ff, acc_in;
   logic                            done_ff, done_in;

   logic [lphm_pkg::KEY_W-1:0]      coef;
   logic [lphm_pkg::HALF_W-1:0]     mul_a;
   logic [lphm_pkg::HALF_W-1:0]     mul_b;
   logic [lphm_pkg::KEY_W-1:0]      prod;
   logic [lphm_pkg::KEY_W-1:0]      prod_full;

   assign coef  = pass_ff ? lphm_pkg::FMIX_C2 : lphm_pkg::FMIX_C1;
   assign mul_a = (state_ff == lphm_pkg::H_HL) ? h_ff[lphm_pkg::KEY_W-1:lphm_pkg::HALF_W]
                                               : h_ff[lphm_pkg::HALF_W-1:0];
   assign mul_b = (state_ff == lphm_pkg::H_LH) ? coef[lphm_pkg::KEY_W-1:lphm_pkg::HALF_W]
                                               : coef[lphm_pkg::HALF_W-1:0];
   assign prod  = lphm_pkg::KEY_W'(mul_a) * lphm_pkg::KEY_W'(mul_b);
   assign prod_full = {acc_ff[lphm_pkg::KEY_W-1:lphm_pkg::HALF_W] + prod[lphm_pkg::HALF_W-1:0],
                       acc_ff[lphm_pkg::HALF_W-1:0]};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lphm_pkg::H_IDLE: begin
            if (hash_req.start) begin
               state_in = lphm_pkg::H_LL;
            end
         end
         lphm_pkg::H_LL: state_in = lphm_pkg::H_LH;
         lphm_pkg::H_LH: state_in = lphm_pkg::H_HL;
         lphm_pkg::H_HL: state_in = pass_ff ? lphm_pkg::H_IDLE : lphm_pkg::H_LL;
         default:        state_in = lphm_pkg::H_IDLE;
      endcase
   end

   always_comb begin
      pass_in = pass_ff;
      h_in    = h_ff;
      acc_in  = acc_ff;
      done_in = 1'b0;
      case (state_ff)
         lphm_pkg::H_IDLE: begin
            if (hash_req.start) begin
               pass_in = 1'b0;
               h_in    = hash_req.key ^ (hash_req.key >> lphm_pkg::FMIX_SHIFT);
            end
         end
         lphm_pkg::H_LL: acc_in = prod;
         lphm_pkg::H_LH: acc_in = prod_full;
         lphm_pkg::H_HL: begin
            // last partial product lands straight in the xor-shift
            h_in    = {acc_ff[lphm_pkg::KEY_W-1:lphm_pkg::HALF_W] + prod[lphm_pkg::HALF_W-1:0],
                       acc_ff[lphm_pkg::HALF_W-1:0]};
            h_in    = h_in ^ (h_in >> lphm_pkg::FMIX_SHIFT);
            pass_in = 1'b1;
            done_in = pass_ff;
         end
         default: done_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lphm_pkg::H_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      pass_ff <= pass_in;
      h_ff    <= h_in;
      acc_ff  <= acc_in;
   end

   assign hash_rsp.done = done_ff;
   assign hash_rsp.slot = h_ff[lphm_pkg::SLOT_BITS-1:0];

endmodule
`default_nettype wire

FILE: rtl/lphm_table.sv
`default_nettype none
// Slot table: one write port, one registered read port.
module lphm_table (
   input  wire logic                     clock,
   input  wire lphm_pkg::tbl_rd_type     tbl_rd,
   input  wire lphm_pkg::tbl_wr_type     tbl_wr,
   output lphm_pkg::slot_entry_type      tbl_rd_data
);

   lphm_pkg::slot_entry_type slot_mem [lphm_pkg::SLOTS];
   lphm_pkg::slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (tbl_wr.en) begin
         slot_mem[tbl_wr.addr] <= tbl_wr.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_rd.en) begin
         rd_data_ff <= slot_mem[tbl_rd.addr];
      end
   end

   assign tbl_rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: rtl/lphm_ctrl.sv
`default_nettype none
// Operation sequencer: sweep, hash wait, probe walk, table update, result register.
module lphm_ctrl (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [lphm_pkg::KIND_W-1:0]     req_kind,
   input  wire logic [lphm_pkg::KEY_W-1:0]      req_key,
   input  wire logic [lphm_pkg::VALUE_W-1:0]    req_new_value,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [lphm_pkg::VALUE_W-1:0]         rsp_old_value,
   output logic                                 rsp_found,
   output logic                                 rsp_status,
   input  wire logic [lphm_pkg::LIMIT_W-1:0]    live_limit,
   output lphm_pkg::hash_req_type               hash_req,
   input  wire lphm_pkg::hash_rsp_type          hash_rsp,
   output lphm_pkg::tbl_rd_type                 tbl_rd,
   output lphm_pkg::tbl_wr_type                 tbl_wr,
   input  wire lphm_pkg::slot_entry_type        tbl_rd_data
);

   lphm_pkg::ctrl_state_type state_ff, state_in;

   logic [lphm_pkg::KIND_W-1:0]    kind_ff, kind_in;
   logic [lphm_pkg::KEY_W-1:0]     key_ff, key_in;
   logic [lphm_pkg::VALUE_W-1:0]   new_value_ff, new_value_in;
   logic [lphm_pkg::LIMIT_W-1:0]   live_count_ff, live_count_in;
   logic [lphm_pkg::SLOT_BITS-1:0] sweep_ff, sweep_in;
   logic                           sweep_reply_ff, sweep_reply_in;
   logic [lphm_pkg::SLOT_BITS-1:0] addr_ff, addr_in;
   logic [lphm_pkg::SLOT_BITS-1:0] chk_ff, chk_in;
   logic [lphm_pkg::SLOT_BITS-1:0] count_ff, count_in;
   logic                           pend_ff, pend_in;
   logic                           hit_ff, hit_in;
   logic [lphm_pkg::SLOT_BITS-1:0] hit_slot_ff, hit_slot_in;
   logic [lphm_pkg::VALUE_W-1:0]   old_ff, old_in;
   logic [lphm_pkg::SLOT_BITS-1:0] free_slot_ff, free_slot_in;
   logic                           have_free_ff, have_free_in;
   logic                           tomb_seen_ff, tomb_seen_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [lphm_pkg::VALUE_W-1:0]   rsp_old_ff, rsp_old_in;
   logic                           rsp_found_ff, rsp_found_in;
   logic                           rsp_status_ff, rsp_status_in;

   logic chk_valid, is_empty, is_hit, is_tomb, at_end, probe_stop;
   logic out_free, accept, is_exch, nv_zero, upd, ins_try, reject, ins_ok, finish_go;

   // Probe check on the entry read in the previous cycle
   assign chk_valid  = (state_ff == lphm_pkg::C_PROBE) && pend_ff;
   assign is_empty   = chk_valid && (tbl_rd_data.mark == lphm_pkg::MARK_EMPTY);
   assign is_hit     = chk_valid && (tbl_rd_data.mark == lphm_pkg::MARK_FULL)
                       && (tbl_rd_data.key == key_ff);
   assign is_tomb    = chk_valid && (tbl_rd_data.mark == lphm_pkg::MARK_TOMB);
   assign at_end     = chk_valid && (count_ff == lphm_pkg::SLOT_MAX);
   assign probe_stop = is_empty || is_hit || at_end;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign accept    = (state_ff == lphm_pkg::C_IDLE) && req_valid;
   assign is_exch   = (kind_ff == lphm_pkg::KIND_EXCHANGE);
   assign nv_zero   = (new_value_ff == '0);
   assign upd       = is_exch && hit_ff;
   assign ins_try   = is_exch && !hit_ff && !nv_zero;
   assign reject    = ins_try && ((live_count_ff >= live_limit) || !have_free_ff);
   assign ins_ok    = ins_try && !reject;
   assign finish_go = (state_ff == lphm_pkg::C_FINISH) && out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lphm_pkg::C_SWEEP: begin
            if (sweep_ff == lphm_pkg::SLOT_MAX) begin
               state_in = sweep_reply_ff ? lphm_pkg::C_FINISH : lphm_pkg::C_IDLE;
            end
         end
         lphm_pkg::C_IDLE: begin
            if (req_valid) begin
               if (req_kind == lphm_pkg::KIND_LOOKUP || req_kind == lphm_pkg::KIND_EXCHANGE) begin
                  state_in = lphm_pkg::C_HASH;
               end else if (req_kind == lphm_pkg::KIND_CLEAR) begin
                  state_in = lphm_pkg::C_SWEEP;
               end else begin
                  state_in = lphm_pkg::C_FINISH;
               end
            end
         end
         lphm_pkg::C_HASH: begin
            if (hash_rsp.done) begin
               state_in = lphm_pkg::C_PROBE;
            end
         end
         lphm_pkg::C_PROBE: begin
            if (probe_stop) begin
               state_in = lphm_pkg::C_FINISH;
            end
         end
         lphm_pkg::C_FINISH: begin
            if (out_free) begin
               state_in = lphm_pkg::C_IDLE;
            end
         end
         default: state_in = lphm_pkg::C_IDLE;
      endcase
   end

   always_comb begin
      req_ready      = (state_ff == lphm_pkg::C_IDLE);
      hash_req.start = accept && (req_kind == lphm_pkg::KIND_LOOKUP
                                  || req_kind == lphm_pkg::KIND_EXCHANGE);
      hash_req.key   = req_key;
      tbl_rd.en      = (state_ff == lphm_pkg::C_PROBE);
      tbl_rd.addr    = addr_ff;
      tbl_wr.en      = 1'b0;
      tbl_wr.addr    = sweep_ff;
      tbl_wr.entry   = '{mark: lphm_pkg::MARK_EMPTY, key: '0, value: '0};
      case (state_ff)
         lphm_pkg::C_SWEEP: tbl_wr.en = 1'b1;
         lphm_pkg::C_FINISH: begin
            if (finish_go && upd) begin
               tbl_wr.en    = 1'b1;
               tbl_wr.addr  = hit_slot_ff;
               tbl_wr.entry = '{mark: (nv_zero ? lphm_pkg::MARK_TOMB : lphm_pkg::MARK_FULL),
                                key: key_ff, value: new_value_ff};
            end else if (finish_go && ins_ok) begin
               tbl_wr.en    = 1'b1;
               tbl_wr.addr  = free_slot_ff;
               tbl_wr.entry = '{mark: lphm_pkg::MARK_FULL, key: key_ff, value: new_value_ff};
            end
         end
         default: tbl_wr.en = 1'b0;
      endcase
   end

   always_comb begin
      kind_in        = kind_ff;
      key_in         = key_ff;
      new_value_in   = new_value_ff;
      live_count_in  = live_count_ff;
      sweep_in       = sweep_ff;
      sweep_reply_in = sweep_reply_ff;
      addr_in        = addr_ff;
      chk_in         = chk_ff;
      count_in       = count_ff;
      pend_in        = pend_ff;
      hit_in         = hit_ff;
      hit_slot_in    = hit_slot_ff;
      old_in         = old_ff;
      free_slot_in   = free_slot_ff;
      have_free_in   = have_free_ff;
      tomb_seen_in   = tomb_seen_ff;
      case (state_ff)
         lphm_pkg::C_SWEEP: sweep_in = sweep_ff + 1'b1;
         lphm_pkg::C_IDLE: begin
            if (accept) begin
               kind_in        = req_kind;
               key_in         = req_key;
               new_value_in   = req_new_value;
               hit_in         = 1'b0;
               have_free_in   = 1'b0;
               tomb_seen_in   = 1'b0;
               sweep_reply_in = (req_kind == lphm_pkg::KIND_CLEAR);
               if (req_kind == lphm_pkg::KIND_CLEAR) begin
                  live_count_in = '0;
               end
            end
         end
         lphm_pkg::C_HASH: begin
            if (hash_rsp.done) begin
               addr_in  = hash_rsp.slot;
               count_in = '0;
               pend_in  = 1'b0;
            end
         end
         lphm_pkg::C_PROBE: begin
            addr_in = addr_ff + 1'b1;
            chk_in  = addr_ff;
            pend_in = 1'b1;
            if (chk_valid) begin
               count_in = count_ff + 1'b1;
            end
            if (is_hit) begin
               hit_in      = 1'b1;
               hit_slot_in = chk_ff;
               old_in      = tbl_rd_data.value;
            end
            if ((is_empty || is_tomb) && !tomb_seen_ff) begin
               free_slot_in = chk_ff;
               have_free_in = 1'b1;
               tomb_seen_in = is_tomb;
            end
         end
         lphm_pkg::C_FINISH: begin
            if (finish_go && upd && nv_zero) begin
               live_count_in = live_count_ff - 1'b1;
            end else if (finish_go && ins_ok) begin
               live_count_in = live_count_ff + 1'b1;
            end
         end
         default: pend_in = 1'b0;
      endcase
   end

   // Result register: load on finish, drop after the transfer
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_old_in    = rsp_old_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      if (finish_go) begin
         rsp_valid_in  = 1'b1;
         rsp_old_in    = hit_ff ? old_ff : '0;
         rsp_found_in  = hit_ff;
         rsp_status_in = reject;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= lphm_pkg::C_SWEEP;
         live_count_ff  <= '0;
         sweep_ff       <= '0;
         sweep_reply_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         live_count_ff  <= live_count_in;
         sweep_ff       <= sweep_in;
         sweep_reply_ff <= sweep_reply_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      new_value_ff  <= new_value_in;
      addr_ff       <= addr_in;
      chk_ff        <= chk_in;
      count_ff      <= count_in;
      pend_ff       <= pend_in;
      hit_ff        <= hit_in;
      hit_slot_ff   <= hit_slot_in;
      old_ff        <= old_in;
      free_slot_ff  <= free_slot_in;
      have_free_ff  <= have_free_in;
      tomb_seen_ff  <= tomb_seen_in;
      rsp_old_ff    <= rsp_old_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_old_value = rsp_old_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_status    = rsp_status_ff;

   a_no_write_in_probe: assert property (@(posedge clock) disable iff (reset)
      state_ff == lphm_pkg::C_PROBE |-> !tbl_wr.en)
      else $error("table written during probe walk");

   a_hash_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      hash_rsp.done |-> state_ff == lphm_pkg::C_HASH)
      else $error("hash finished outside hash wait");

   a_insert_counts: assert property (@(posedge clock) disable iff (reset)
      finish_go && ins_ok |=>
         live_count_ff == lphm_pkg::LIMIT_W'($past(live_count_ff) + 1'b1))
      else $error("live count not advanced on insert");

   a_sweep_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> state_ff == lphm_pkg::C_SWEEP && !req_ready)
      else $error("no clearing sweep after reset");

   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == lphm_pkg::C_FINISH)
      else $error("result loaded outside finish");

endmodule
`default_nettype wire

FILE: rtl/linear_probe_hash_map_unit.sv
`default_nettype none
// Open-addressing map of 1024 slots from 64-bit keys to 32-bit values, with
// linear probing and tombstones. Kind 0 looks a key up, kind 1 exchanges its
// value (zero removes it), kind 2 clears the whole table; every transfer in
// gives exactly one result. After reset the block sweeps all 1024 slot marks
// to empty, one slot a cycle, and holds req_ready low during the sweep; a
// clear runs the same sweep and answers once it is done. For a lookup or
// exchange the fmix64 hash runs six steps on one shared 32x32 multiplier,
// then the probe reads one slot a cycle from the slot memory's read port,
// examines at least one and at most 1024 slots, and stops at the key, an
// empty slot or after a full lap. The result sits in an output register, so
// the next item is taken while an earlier result still waits for rsp_ready.
// csr_wr_data sets the live-entry limit (reset 716); write it only while the
// block is idle.
module linear_probe_hash_map_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request channel
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [lphm_pkg::KIND_W-1:0]     req_kind,
   input  wire logic [lphm_pkg::KEY_W-1:0]      req_key,
   input  wire logic [lphm_pkg::VALUE_W-1:0]    req_new_value,
   // response channel
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [lphm_pkg::VALUE_W-1:0]         rsp_old_value,
   output logic                                 rsp_found,
   output logic                                 rsp_status,
   // live limit register
   input  wire logic                            csr_wr_en,
   input  wire logic [lphm_pkg::LIMIT_W-1:0]    csr_wr_data
);

   logic [lphm_pkg::LIMIT_W-1:0] live_limit_ff, live_limit_in;

   lphm_pkg::hash_req_type   hash_req;
   lphm_pkg::hash_rsp_type   hash_rsp;
   lphm_pkg::tbl_rd_type     tbl_rd;
   lphm_pkg::tbl_wr_type     tbl_wr;
   lphm_pkg::slot_entry_type tbl_rd_data;

   // Take a new limit on every write strobe; no handshake on this port
   assign live_limit_in = csr_wr_en ? csr_wr_data : live_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         live_limit_ff <= lphm_pkg::LIVE_LIMIT_RESET;
      end else begin
         live_limit_ff <= live_limit_in;
      end
   end

   // Hash unit: one start per lookup or exchange, slot index out on done
   lphm_hash u_hash (
      .clock    (clock),
      .reset    (reset),
      .hash_req (hash_req),
      .hash_rsp (hash_rsp)
   );

   // Slot memory: mark, key and value side by side in one entry
   lphm_table u_table (
      .clock       (clock),
      .tbl_rd      (tbl_rd),
      .tbl_wr      (tbl_wr),
      .tbl_rd_data (tbl_rd_data)
   );

   // Sequencer: handshakes, probe walk, update and result register
   lphm_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_key       (req_key),
      .req_new_value (req_new_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_old_value (rsp_old_value),
      .rsp_found     (rsp_found),
      .rsp_status    (rsp_status),
      .live_limit    (live_limit_ff),
      .hash_req      (hash_req),
      .hash_rsp      (hash_rsp),
      .tbl_rd        (tbl_rd),
      .tbl_wr        (tbl_wr),
      .tbl_rd_data   (tbl_rd_data)
   );

endmodule
`default_nettype wire

FILE: verif/tb_linear_probe_hash_map_unit.sv
`default_nettype none
module tb_linear_probe_hash_map_unit;

   // Kind 3 has no meaning: the block must leave the table alone and answer zeros.
   localparam logic [lphm_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

   // Worst correct run: about 620 transfers, each a full probe lap or a clear sweep,
   // plus sender gaps and receiver stalls. Allow several times that.
   localparam int CYCLE_LIMIT  = 6_000_000;
   // Longest single operation is a full lap or a clear sweep.
   localparam int DRAIN_CYCLES = 1200;
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_CYCLES  = 400;
   localparam int MAX_PRINTS   = 40;

   typedef struct packed {
      logic [lphm_pkg::KIND_W-1:0]  kind;
      logic [lphm_pkg::KEY_W-1:0]   key;
      logic [lphm_pkg::VALUE_W-1:0] value;
   } map_op_type;

   typedef struct packed {
      logic [lphm_pkg::VALUE_W-1:0] old_value;
      logic                         found;
      logic                         status;
   } map_reply_type;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   logic                           clock;
   logic                           reset         = 1'b1;
   logic                           req_valid     = 1'b0;
   logic                           req_ready;
   logic [lphm_pkg::KIND_W-1:0]    req_kind      = '0;
   logic [lphm_pkg::KEY_W-1:0]     req_key       = '0;
   logic [lphm_pkg::VALUE_W-1:0]   req_new_value = '0;
   logic                           rsp_valid;
   logic                           rsp_ready     = 1'b0;
   logic [lphm_pkg::VALUE_W-1:0]   rsp_old_value;
   logic                           rsp_found;
   logic                           rsp_status;
   logic                           csr_wr_en     = 1'b0;
   logic [lphm_pkg::LIMIT_W-1:0]   csr_wr_data   = '0;

   idle_mode_type                  mode          = IDLE_NONE;
   logic                           hold_kick     = 1'b0;
   int                             hold_left     = 0;
   int                             cycles        = 0;
   int                             errors        = 0;
   int                             results_seen  = 0;

   map_op_type                     ops_waiting [$];   // items not yet offered
   map_reply_type                  replies_due [$];   // predicted results, oldest first
   logic [lphm_pkg::KEY_W-1:0]     key_pool [$];

   // Shadow copy of the table, kept in step with every transfer in.
   lphm_pkg::mark_type             tbl_mark [lphm_pkg::SLOTS];
   logic [lphm_pkg::KEY_W-1:0]     tbl_key [lphm_pkg::SLOTS];
   logic [lphm_pkg::VALUE_W-1:0]   tbl_val [lphm_pkg::SLOTS];
   logic [lphm_pkg::LIMIT_W-1:0]   live_cnt;
   logic [lphm_pkg::LIMIT_W-1:0]   live_lim;

   linear_probe_hash_map_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_key       (req_key),
      .req_new_value (req_new_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_old_value (rsp_old_value),
      .rsp_found     (rsp_found),
      .rsp_status    (rsp_status),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // fmix64 finalizer, masked down to the table index.
   function automatic logic [lphm_pkg::SLOT_BITS-1:0] home_slot(
      input logic [lphm_pkg::KEY_W-1:0] k);
      logic [lphm_pkg::KEY_W-1:0] h;
      h = k;
      h ^= h >> lphm_pkg::FMIX_SHIFT;
      h = h * lphm_pkg::FMIX_C1;
      h ^= h >> lphm_pkg::FMIX_SHIFT;
      h = h * lphm_pkg::FMIX_C2;
      h ^= h >> lphm_pkg::FMIX_SHIFT;
      return h[lphm_pkg::SLOT_BITS-1:0];
   endfunction

   // Apply one operation to the shadow table and return the result it must give.
   function automatic map_reply_type map_apply(input map_op_type op);
      map_reply_type                  r;
      logic [lphm_pkg::SLOT_BITS-1:0] s;
      logic [lphm_pkg::SLOT_BITS-1:0] spare;
      bit                             hit;
      bit                             have_spare;
      bit                             tomb_seen;
      bit                             stop;
      r = '0;
      if (op.kind == lphm_pkg::KIND_CLEAR) begin
         foreach (tbl_mark[i]) tbl_mark[i] = lphm_pkg::MARK_EMPTY;
         live_cnt = '0;
         return r;
      end
      if (op.kind != lphm_pkg::KIND_LOOKUP && op.kind != lphm_pkg::KIND_EXCHANGE)
         return r;
      s          = home_slot(op.key);
      spare      = '0;
      hit        = 1'b0;
      have_spare = 1'b0;
      tomb_seen  = 1'b0;
      stop       = 1'b0;
      // Walk at most one lap; remember the first tombstone, else the ending empty slot.
      for (int n = 0; n < lphm_pkg::SLOTS && !stop; n++) begin
         case (tbl_mark[s])
            lphm_pkg::MARK_EMPTY: begin
               if (!tomb_seen) begin
                  spare      = s;
                  have_spare = 1'b1;
               end
               stop = 1'b1;
            end
            lphm_pkg::MARK_FULL: begin
               if (tbl_key[s] == op.key) begin
                  hit  = 1'b1;
                  stop = 1'b1;
               end
            end
            lphm_pkg::MARK_TOMB: begin
               if (!tomb_seen) begin
                  tomb_seen  = 1'b1;
                  spare      = s;
                  have_spare = 1'b1;
               end
            end
            default: ;
         endcase
         if (!stop) s = s + 1'b1;
      end
      if (hit) begin
         r.old_value = tbl_val[s];
         r.found     = 1'b1;
         if (op.kind == lphm_pkg::KIND_EXCHANGE) begin
            if (op.value == '0) begin
               tbl_mark[s] = lphm_pkg::MARK_TOMB;
               live_cnt    = live_cnt - 1'b1;
            end else begin
               tbl_val[s] = op.value;
            end
         end
      end else if (op.kind == lphm_pkg::KIND_EXCHANGE && op.value != '0) begin
         // An update of a present key never gets here, so the limit only blocks new keys.
         if (live_cnt >= live_lim || !have_spare) begin
            r.status = 1'b1;
         end else begin
            tbl_key[spare]  = op.key;
            tbl_val[spare]  = op.value;
            tbl_mark[spare] = lphm_pkg::MARK_FULL;
            live_cnt        = live_cnt + 1'b1;
         end
      end
      return r;
   endfunction

   function automatic logic [lphm_pkg::KEY_W-1:0] rand_key();
      return {$urandom, $urandom};
   endfunction

   // Search random keys until one hashes to the wanted home slot.
   function automatic logic [lphm_pkg::KEY_W-1:0] key_at_home(
      input logic [lphm_pkg::SLOT_BITS-1:0] slot);
      logic [lphm_pkg::KEY_W-1:0] k;
      k = rand_key();
      while (home_slot(k) != slot) k = rand_key();
      return k;
   endfunction

   function automatic logic [lphm_pkg::VALUE_W-1:0] pick_value();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 25) return '0;
      if (r < 32) return '1;
      if (r < 45) return lphm_pkg::VALUE_W'($urandom_range(15, 1));
      return $urandom;
   endfunction

   function automatic int unsigned sender_gap_pct(input idle_mode_type m);
      case (m)
         IDLE_SENDER: return 84;
         IDLE_BOTH:   return 35;
         default:     return 0;
      endcase
   endfunction

   function automatic int unsigned receiver_stall_pct(input idle_mode_type m);
      case (m)
         IDLE_RECEIVER: return 84;
         IDLE_BOTH:     return 35;
         default:       return 0;
      endcase
   endfunction

   task automatic report(input string what);
      errors++;
      if (errors <= MAX_PRINTS)
         $display("cycle %0d: %s", cycles, what);
   endtask

   task automatic post(input logic [lphm_pkg::KIND_W-1:0] kind,
                       input logic [lphm_pkg::KEY_W-1:0] k,
                       input logic [lphm_pkg::VALUE_W-1:0] v);
      map_op_type op;
      op = '{kind: kind, key: k, value: v};
      ops_waiting.insert(ops_waiting.size(), op);
   endtask

   // Pool of keys for the random part: some loose, some sharing a home slot so
   // that probes run past neighbors, tombstones and the end of the table.
   task automatic build_pool(input int loose, input int clusters);
      logic [lphm_pkg::SLOT_BITS-1:0] h;
      key_pool.delete();
      for (int i = 0; i < loose; i++) key_pool.insert(key_pool.size(), rand_key());
      for (int i = 0; i < clusters; i++) begin
         h = ($urandom_range(3) == 0) ? lphm_pkg::SLOT_MAX
                                      : lphm_pkg::SLOT_BITS'($urandom);
         key_pool.insert(key_pool.size(), key_at_home(h));
         key_pool.insert(key_pool.size(), key_at_home(h));
         key_pool.insert(key_pool.size(), key_at_home(h + 1'b1));
      end
   endtask

   task automatic queue_random(input int count, input int clear_pct);
      int unsigned                r;
      logic [lphm_pkg::KEY_W-1:0] k;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (key_pool.size() != 0 && $urandom_range(99) < 85)
            k = key_pool[$urandom_range(key_pool.size() - 1)];
         else
            k = rand_key();
         if (r < clear_pct)
            post(lphm_pkg::KIND_CLEAR, k, $urandom);
         else if (r < clear_pct + 2)
            post(KIND_UNUSED, k, $urandom);
         else if (r < 40)
            post(lphm_pkg::KIND_LOOKUP, k, $urandom);
         else
            post(lphm_pkg::KIND_EXCHANGE, k, pick_value());
      end
   endtask

   // Wait until every item is offered and every result is back; sample at the
   // falling edge so the driver and monitor have settled.
   task automatic wait_quiet();
      while (ops_waiting.size() != 0 || req_valid || replies_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Drain, write the live limit, switch the idling pattern, then hand back at a
   // falling edge so new items are queued clear of the driver.
   task automatic start_phase(input idle_mode_type m,
                              input logic [lphm_pkg::LIMIT_W-1:0] lim);
      wait_quiet();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= lim;
      mode        <= m;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      live_lim = lim;
      @(negedge clock);
   endtask

   // Request driver: hold valid and payload until the transfer, then advance.
   always @(posedge clock) begin : drive
      map_op_type    nxt;
      map_reply_type due;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // A transfer happened at this edge: predict its result now.
         if (req_valid && req_ready) begin
            due = map_apply('{kind: req_kind, key: req_key, value: req_new_value});
            replies_due.insert(replies_due.size(), due);
         end
         if (!req_valid || req_ready) begin
            if (ops_waiting.size() != 0 && $urandom_range(99) >= sender_gap_pct(mode)) begin
               nxt = ops_waiting.pop_front();
               req_valid     <= 1'b1;
               req_kind      <= nxt.kind;
               req_key       <= nxt.key;
               req_new_value <= nxt.value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, counted here so the monitor only has to look at it.
   always @(posedge clock) begin
      if (reset)
         hold_left <= 0;
      else if (hold_kick)
         hold_left <= HOLD_CYCLES;
      else if (hold_left != 0)
         hold_left <= hold_left - 1;
   end

   // Result monitor: compare each transfer out with the oldest prediction.
   always @(posedge clock) begin : watch
      map_reply_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (replies_due.size() == 0) begin
               report("result arrived with nothing outstanding");
            end else begin
               want = replies_due.pop_front();
               if (rsp_old_value !== want.old_value)
                  report($sformatf("result %0d old_value %h, expected %h",
                                   results_seen, rsp_old_value, want.old_value));
               if (rsp_found !== want.found)
                  report($sformatf("result %0d found %b, expected %b",
                                   results_seen, rsp_found, want.found));
               if (rsp_status !== want.status)
                  report($sformatf("result %0d status %b, expected %b",
                                   results_seen, rsp_status, want.status));
            end
            results_seen++;
         end
         rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= receiver_stall_pct(mode));
      end
   end

   // Watchdog: end a hung run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      logic [lphm_pkg::KEY_W-1:0] kw [4];

      foreach (tbl_mark[i]) tbl_mark[i] = lphm_pkg::MARK_EMPTY;
      live_cnt = '0;
      live_lim = lphm_pkg::LIVE_LIMIT_RESET;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part, reset limit. Four keys share home slot 1023, so their
      // cluster wraps to the start of the table.
      foreach (kw[i]) kw[i] = key_at_home(lphm_pkg::SLOT_MAX);
      post(lphm_pkg::KIND_LOOKUP,   kw[0], '0);             // miss on an empty table
      post(lphm_pkg::KIND_EXCHANGE, kw[0], '1);
      post(lphm_pkg::KIND_EXCHANGE, kw[1], 32'd1);
      post(lphm_pkg::KIND_EXCHANGE, kw[2], 32'h8000_0000);  // lands past the wrap
      post(lphm_pkg::KIND_EXCHANGE, '0, 32'd5);
      post(lphm_pkg::KIND_EXCHANGE, '1, 32'd6);
      post(lphm_pkg::KIND_LOOKUP,   kw[2], '0);
      post(lphm_pkg::KIND_EXCHANGE, kw[0], '0);   // remove, leave a tombstone at home
      post(lphm_pkg::KIND_LOOKUP,   kw[2], '0);   // probe must step over the tombstone
      post(lphm_pkg::KIND_EXCHANGE, kw[0], '0);   // remove an absent key
      post(lphm_pkg::KIND_LOOKUP,   kw[0], '0);
      post(lphm_pkg::KIND_EXCHANGE, kw[3], 32'd7);  // new key takes the tombstone
      post(lphm_pkg::KIND_EXCHANGE, kw[1], 32'd9);  // update in place
      post(lphm_pkg::KIND_LOOKUP,   kw[3], '0);
      post(KIND_UNUSED,             kw[1], 32'd3);
      post(lphm_pkg::KIND_LOOKUP,   kw[1], '0);
      post(lphm_pkg::KIND_LOOKUP,   '0, '1);      // lookup ignores the value field
      post(lphm_pkg::KIND_CLEAR,    '0, '0);
      post(lphm_pkg::KIND_LOOKUP,   kw[2], '0);
      post(lphm_pkg::KIND_EXCHANGE, kw[2], '0);
      post(lphm_pkg::KIND_EXCHANGE, kw[2], 32'd11);
      post(lphm_pkg::KIND_LOOKUP,   '1, '0);

      // Limit zero: every new key is turned away, the one present key still updates.
      start_phase(IDLE_SENDER, lphm_pkg::LIMIT_W'(0));
      build_pool(3, 0);
      key_pool.insert(key_pool.size(), kw[2]);
      queue_random(40, 0);

      // Tiny limit with a small pool, so the limit is hit again and again.
      start_phase(IDLE_RECEIVER, lphm_pkg::LIMIT_W'(3));
      build_pool(2, 2);
      queue_random(150, 2);

      // Limit equal to the slot count, no idling, and one long receiver hold-off
      // while the sender keeps offering, so the block backs up to its input.
      start_phase(IDLE_NONE, lphm_pkg::LIMIT_W'(1024));
      build_pool(16, 8);
      queue_random(200, 1);
      @(posedge clock);
      hold_kick <= 1'b1;
      @(posedge clock);
      hold_kick <= 1'b0;

      // Largest field value: the limit never binds, every new key goes in.
      start_phase(IDLE_NONE, lphm_pkg::LIMIT_W'(2047));
      build_pool(8, 4);
      queue_random(40, 1);

      // Limit one: a single live entry at a time.
      start_phase(IDLE_BOTH, lphm_pkg::LIMIT_W'(1));
      build_pool(3, 1);
      queue_random(80, 2);

      // Back to the reset value with a wider pool.
      start_phase(IDLE_SENDER, lphm_pkg::LIVE_LIMIT_RESET);
      build_pool(12, 4);
      queue_random(90, 1);

      wait_quiet();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
`default_nettype wire
